// ----- sv/ssd2d_pkg.sv -----
// Shared constants for the 2D segment-to-segment distance block.
// No dependencies; used by ssd2d_front and the top level by scoped name.
package ssd2d_pkg;

  // Result width and its saturation value
  localparam int unsigned DIST_W = 33;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Lanes: one per end point measured against the opposite segment
  localparam int unsigned LANES = 4;

endpackage

// ----- sv/ssd2d_front.sv -----
// Front end of the distance pipeline: differences, products, sums, classification
// and numerator/denominator forming for the four end-point lanes (six stages).
// Depends on ssd2d_pkg.
module ssd2d_front #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [COORD_BITS-1:0]          pt_i  [8],
  output logic                                  valid_o,
  output logic [4*COORD_BITS+1+2*FRAC_BITS:0]   num_o [ssd2d_pkg::LANES],
  output logic [2*COORD_BITS:0]                 den_o [ssd2d_pkg::LANES]
);

  localparam int unsigned L   = ssd2d_pkg::LANES;
  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * COORD_BITS + 2;
  localparam int unsigned SW  = 2 * COORD_BITS + 3;
  localparam int unsigned AW  = 2 * COORD_BITS + 1;
  localparam int unsigned KW  = COORD_BITS + 1;
  localparam int unsigned HW  = AW - KW;
  localparam int unsigned SQW = 2 * AW;
  localparam int unsigned NW  = SQW + 2 * FRAC_BITS;
  localparam int unsigned DDW = 2 * COORD_BITS + 1;

  // stage 1
  logic signed [COORD_BITS-1:0] ax [L], ay [L], bx [L], by [L];
  logic [L-1:0] box;
  logic signed [DW-1:0] wx_q [L], wy_q [L], ex_q [L], ey_q [L];
  logic signed [DW-1:0] dx_q [2], dy_q [2];
  logic [L-1:0] box1_q;
  logic v1_q;

  // stage 2
  logic signed [PW-1:0] pwx_q [L], pwy_q [L], pex_q [L], pey_q [L];
  logic signed [PW-1:0] pdotx_q [L], pdoty_q [L], pcrx_q [L], pcry_q [L];
  logic signed [PW-1:0] pdx_q [2], pdy_q [2];
  logic [L-1:0] box2_q;
  logic v2_q;

  // stage 3
  logic signed [SW-1:0] w2_q [L], e2_q [L], wd_q [L], c_q [L], dd_q [2];
  logic [L-1:0] box3_q;
  logic v3_q;

  // stage 4
  logic [L-1:0] cz, cn;
  logic meet_d;
  logic signed [SW-1:0] acf [L];
  logic [AW-1:0] lin_d [L];
  logic [L-1:0] inr_d;
  logic [DDW-1:0] den4_d [L];
  logic [AW-1:0] lin_q [L];
  logic [L-1:0] inr_q;
  logic [HW-1:0] hi_q [L];
  logic [KW-1:0] lo_q [L];
  logic [DDW-1:0] den4_q [L];
  logic meet4_q, v4_q;

  // stage 5
  logic [2*HW-1:0] hh_q [L];
  logic [HW+KW-1:0] hl_q [L];
  logic [2*KW-1:0] ll_q [L];
  logic [AW-1:0] lin5_q [L];
  logic [L-1:0] inr5_q;
  logic [DDW-1:0] den5_q [L];
  logic meet5_q, v5_q;

  // stage 6
  logic [SQW-1:0] sq [L];
  logic [NW-1:0] num_q [L];
  logic [DDW-1:0] den6_q [L];
  logic v6_q;

  // Lanes 0/1: first-segment end points against the second segment; 2/3 the reverse
  always_comb begin
    for (int j = 0; j < L; j++) begin
      ax[j] = (j < 2) ? pt_i[4] : pt_i[0];
      ay[j] = (j < 2) ? pt_i[5] : pt_i[1];
      bx[j] = (j < 2) ? pt_i[6] : pt_i[2];
      by[j] = (j < 2) ? pt_i[7] : pt_i[3];
      box[j] = (pt_i[2*j] >= ax[j] || pt_i[2*j] >= bx[j]) &&
               (pt_i[2*j] <= ax[j] || pt_i[2*j] <= bx[j]) &&
               (pt_i[2*j+1] >= ay[j] || pt_i[2*j+1] >= by[j]) &&
               (pt_i[2*j+1] <= ay[j] || pt_i[2*j+1] <= by[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      wx_q[j] <= DW'(pt_i[2*j])   - DW'(ax[j]);
      wy_q[j] <= DW'(pt_i[2*j+1]) - DW'(ay[j]);
      ex_q[j] <= DW'(pt_i[2*j])   - DW'(bx[j]);
      ey_q[j] <= DW'(pt_i[2*j+1]) - DW'(by[j]);
    end
    dx_q[0] <= DW'(pt_i[2]) - DW'(pt_i[0]);
    dy_q[0] <= DW'(pt_i[3]) - DW'(pt_i[1]);
    dx_q[1] <= DW'(pt_i[6]) - DW'(pt_i[4]);
    dy_q[1] <= DW'(pt_i[7]) - DW'(pt_i[5]);
    box1_q  <= box;
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      pwx_q[j]   <= wx_q[j] * wx_q[j];
      pwy_q[j]   <= wy_q[j] * wy_q[j];
      pex_q[j]   <= ex_q[j] * ex_q[j];
      pey_q[j]   <= ey_q[j] * ey_q[j];
      pdotx_q[j] <= wx_q[j] * dx_q[(j < 2) ? 1 : 0];
      pdoty_q[j] <= wy_q[j] * dy_q[(j < 2) ? 1 : 0];
      pcrx_q[j]  <= dx_q[(j < 2) ? 1 : 0] * wy_q[j];
      pcry_q[j]  <= dy_q[(j < 2) ? 1 : 0] * wx_q[j];
    end
    for (int s = 0; s < 2; s++) begin
      pdx_q[s] <= dx_q[s] * dx_q[s];
      pdy_q[s] <= dy_q[s] * dy_q[s];
    end
    box2_q <= box1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      w2_q[j] <= SW'(pwx_q[j]) + SW'(pwy_q[j]);
      e2_q[j] <= SW'(pex_q[j]) + SW'(pey_q[j]);
      wd_q[j] <= SW'(pdotx_q[j]) + SW'(pdoty_q[j]);
      c_q[j]  <= SW'(pcrx_q[j]) - SW'(pcry_q[j]);
    end
    for (int s = 0; s < 2; s++) begin
      dd_q[s] <= SW'(pdx_q[s]) + SW'(pdy_q[s]);
    end
    box3_q <= box2_q;
  end

  // Cross products double as the orientation tests of the crossing check
  always_comb begin
    for (int j = 0; j < L; j++) begin
      cz[j]  = (c_q[j] == '0);
      cn[j]  = c_q[j][SW-1];
      acf[j] = cn[j] ? -c_q[j] : c_q[j];
      if (dd_q[(j < 2) ? 1 : 0] == '0 || wd_q[j][SW-1] || wd_q[j] == '0) begin
        lin_d[j]  = AW'(w2_q[j]);
        inr_d[j]  = 1'b0;
        den4_d[j] = DDW'(1);
      end else if (wd_q[j] >= dd_q[(j < 2) ? 1 : 0]) begin
        lin_d[j]  = AW'(e2_q[j]);
        inr_d[j]  = 1'b0;
        den4_d[j] = DDW'(1);
      end else begin
        lin_d[j]  = AW'(w2_q[j]);
        inr_d[j]  = 1'b1;
        den4_d[j] = DDW'(dd_q[(j < 2) ? 1 : 0]);
      end
    end
    meet_d = (((cz[2] != cz[3]) || (cn[2] != cn[3])) &&
              ((cz[0] != cz[1]) || (cn[0] != cn[1]))) ||
             (|(cz & box3_q));
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      lin_q[j]  <= lin_d[j];
      hi_q[j]   <= acf[j][AW-1:KW];
      lo_q[j]   <= acf[j][KW-1:0];
      den4_q[j] <= den4_d[j];
    end
    inr_q   <= inr_d;
    meet4_q <= meet_d;
  end

  // |c|^2 as three partial products
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      hh_q[j]   <= hi_q[j] * hi_q[j];
      hl_q[j]   <= hi_q[j] * lo_q[j];
      ll_q[j]   <= lo_q[j] * lo_q[j];
      lin5_q[j] <= lin_q[j];
      den5_q[j] <= den4_q[j];
    end
    inr5_q  <= inr_q;
    meet5_q <= meet4_q;
  end

  always_comb begin
    for (int j = 0; j < L; j++) begin
      sq[j] = (SQW'(hh_q[j]) << (2 * KW)) + (SQW'(hl_q[j]) << (KW + 1)) + SQW'(ll_q[j]);
    end
  end

  // crossing segments force every numerator to zero
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < L; j++) begin
      if (meet5_q) begin
        num_q[j] <= '0;
      end else if (inr5_q[j]) begin
        num_q[j] <= NW'(sq[j]) << (2 * FRAC_BITS);
      end else begin
        num_q[j] <= NW'(lin5_q[j]) << (2 * FRAC_BITS);
      end
      den6_q[j] <= den5_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign valid_o = v6_q;
  assign num_o   = num_q;
  assign den_o   = den6_q;

endmodule

// ----- sv/ssd2d_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Needs numerator / denominator < 2^Q_W. No package dependency.
module ssd2d_div #(
  parameter int unsigned DEN_W = 49,
  parameter int unsigned Q_W   = 65
) (
  input  logic                   clk_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [Q_W-1:0]         q_o
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   nq_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] r_in, d_in;
    logic [Q_W-1:0]   n_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = num_i[DEN_W+Q_W-1:Q_W];
      assign d_in = den_i;
      assign n_in = num_i[Q_W-1:0];
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign n_in = nq_q[k-1];
    end

    // nq holds the unused numerator bits above and the quotient bits below
    assign trial = {r_in, n_in[Q_W-1]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
      den_q[k] <= d_in;
      nq_q[k]  <= {n_in[Q_W-2:0], ge};
    end
  end

  assign q_o = nq_q[Q_W-1];

endmodule

// ----- sv/ssd2d_sqrt.sv -----
// Pipelined integer square root (floor), one root bit per stage.
// No package dependency.
module ssd2d_sqrt #(
  parameter int unsigned IN_W = 65
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [IN_W-1:0]          x_i,
  output logic                     valid_o,
  output logic [(IN_W+1)/2-1:0]    root_o
);

  localparam int unsigned RW  = (IN_W + 1) / 2;
  localparam int unsigned X2  = 2 * RW;
  localparam int unsigned RMW = RW + 2;

  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [X2-1:0]  x_q    [RW];
  logic [RW-1:0]  v_q;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RMW-1:0]   r_in;
    logic [RW-1:0]    rt_in;
    logic [X2-1:0]    x_in;
    logic [RMW+1:0]   sh, trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in  = '0;
      assign rt_in = '0;
      assign x_in  = X2'(x_i);
    end else begin : g_next
      assign r_in  = rem_q[k-1];
      assign rt_in = root_q[k-1];
      assign x_in  = x_q[k-1];
    end

    assign sh    = {r_in, x_in[X2-1:X2-2]};
    assign trial = (RMW+2)'({rt_in, 2'b01});
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RMW'(sh - trial) : RMW'(sh);
      root_q[k] <= {rt_in[RW-2:0], ge};
      x_q[k]    <= x_in << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[RW-2:0], valid_i};
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

// ----- sv/segment_segment_distance_2d_top.sv -----
// An item passes from start to done_o through the front end, the one-bit-per-stage divider
// and square root pipelines, the minimum tree and the saturation register.
// Throughput: one item per cycle; busy stays low and results cannot be held off.
// Reset clears only the valid bits of the pipeline; items in flight are dropped.
// Top level: front end, four dividers, minimum tree, square root, saturation.
// Depends on ssd2d_pkg, ssd2d_front, ssd2d_div, ssd2d_sqrt.
module segment_segment_distance_2d_top #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        first_start_x_i,
  input  logic signed [COORD_BITS-1:0]        first_start_y_i,
  input  logic signed [COORD_BITS-1:0]        first_end_x_i,
  input  logic signed [COORD_BITS-1:0]        first_end_y_i,
  input  logic signed [COORD_BITS-1:0]        second_start_x_i,
  input  logic signed [COORD_BITS-1:0]        second_start_y_i,
  input  logic signed [COORD_BITS-1:0]        second_end_x_i,
  input  logic signed [COORD_BITS-1:0]        second_end_y_i,
  output logic                                done_o,
  output logic [ssd2d_pkg::DIST_W-1:0]        distance_o
);

  localparam int unsigned L   = ssd2d_pkg::LANES;
  localparam int unsigned DDW = 2 * COORD_BITS + 1;
  localparam int unsigned QW  = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
  localparam int unsigned NW  = DDW + QW;
  localparam int unsigned RW  = (QW + 1) / 2;
  localparam int unsigned DW  = ssd2d_pkg::DIST_W;
  localparam int unsigned XW  = (RW > DW) ? RW : DW;
  localparam int unsigned LAT = 6 + QW + 2 + RW + 1;

  logic signed [COORD_BITS-1:0] pt [8];
  logic            fv;
  logic [NW-1:0]   num [L];
  logic [DDW-1:0]  den [L];
  logic [QW-1:0]   dq  [L];
  logic [QW-1:0]   dv_q;
  logic [QW-1:0]   m01_q, m23_q, m_q;
  logic            mv1_q, mv2_q;
  logic            sv;
  logic [RW-1:0]   root;
  logic [XW-1:0]   rt;
  logic [DW-1:0]   dist_q;
  logic            done_q;

  assign busy = 1'b0;

  assign pt[0] = first_start_x_i;
  assign pt[1] = first_start_y_i;
  assign pt[2] = first_end_x_i;
  assign pt[3] = first_end_y_i;
  assign pt[4] = second_start_x_i;
  assign pt[5] = second_start_y_i;
  assign pt[6] = second_end_x_i;
  assign pt[7] = second_end_y_i;

  ssd2d_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .pt_i    (pt),
    .valid_o (fv),
    .num_o   (num),
    .den_o   (den)
  );

  // scaled squared distance per lane: num / den
  for (genvar j = 0; j < L; j++) begin : g_div
    ssd2d_div #(
      .DEN_W (DDW),
      .Q_W   (QW)
    ) u_div (
      .clk_i (clk_i),
      .num_i (num[j]),
      .den_i (den[j]),
      .q_o   (dq[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q  <= '0;
      mv1_q <= 1'b0;
      mv2_q <= 1'b0;
    end else begin
      dv_q  <= {dv_q[QW-2:0], fv};
      mv1_q <= dv_q[QW-1];
      mv2_q <= mv1_q;
    end
  end

  // root is monotone, so take the minimum before the square root
  always_ff @(posedge clk_i) begin
    m01_q <= (dq[0] < dq[1]) ? dq[0] : dq[1];
    m23_q <= (dq[2] < dq[3]) ? dq[2] : dq[3];
    m_q   <= (m01_q < m23_q) ? m01_q : m23_q;
  end

  ssd2d_sqrt #(
    .IN_W (QW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mv2_q),
    .x_i     (m_q),
    .valid_o (sv),
    .root_o  (root)
  );

  assign rt = XW'(root);

  always_ff @(posedge clk_i) begin
    dist_q <= (rt > XW'(ssd2d_pkg::DIST_MAX)) ? ssd2d_pkg::DIST_MAX : DW'(rt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sv;
    end
  end

  assign done_o     = done_q;
  assign distance_o = dist_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("item did not come out after the pipeline latency");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result strobe without an accepted item");

  a_minimum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv2_q |-> (m_q <= $past(dq[0], 2)) && (m_q <= $past(dq[1], 2)) &&
              (m_q <= $past(dq[2], 2)) && (m_q <= $past(dq[3], 2)))
    else $error("minimum tree lost the smallest lane");

endmodule
